// ===== rtl/des_pkg.sv =====
// ----------------------------------------------------------------------------
// DES package
// Tables, permutation helpers and shared types for the DES encrypt pipeline.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int ROUND_COUNT = 16;
  localparam int BlockW = 64;
  localparam int HalfW = 32;
  localparam int KeyHalfW = 28;
  localparam int SubKeyW = 48;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [HalfW-1:0] half_t;
  typedef logic [KeyHalfW-1:0] khalf_t;
  typedef logic [SubKeyW-1:0] subkey_t;

  typedef struct packed {
    logic valid;
    half_t l;
    half_t r;
  } rnd_t;

  typedef logic [7:0] tab_entry_t;
  typedef tab_entry_t tab64_t[64];
  typedef tab_entry_t tab56_t[56];
  typedef tab_entry_t tab48_t[48];
  typedef tab_entry_t tab32_t[32];

  localparam tab64_t TabIp = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab64_t TabFp = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam tab48_t TabE = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam tab32_t TabP = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam tab56_t TabPc1 = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};
  localparam tab48_t TabPc2 = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [1:0] TabRot[ROUND_COUNT] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  typedef logic [3:0] sbox_t[8][64];
  localparam sbox_t TabS = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Output bit i (DES numbering, 1 = MSB) takes input bit tab[i-1].
  function automatic block_t perm_ip(block_t v);
    block_t o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64 - int'(TabIp[i])];
    return o;
  endfunction

  function automatic block_t perm_fp(block_t v);
    block_t o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64 - int'(TabFp[i])];
    return o;
  endfunction

  function automatic logic [55:0] perm_pc1(block_t v);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) o[55-i] = v[64 - int'(TabPc1[i])];
    return o;
  endfunction

  function automatic subkey_t perm_pc2(logic [55:0] v);
    subkey_t o;
    for (int i = 0; i < 48; i++) o[47-i] = v[56 - int'(TabPc2[i])];
    return o;
  endfunction

  function automatic khalf_t rot28(khalf_t h, logic [1:0] s);
    return (s == 2'd2) ? {h[25:0], h[27:26]} : {h[26:0], h[27]};
  endfunction

  function automatic half_t feistel(half_t r, subkey_t k);
    subkey_t x;
    half_t o;
    half_t p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
    x = x ^ k;
    for (int j = 0; j < 8; j++) begin
      six = x[47-6*j -: 6];
      o[31-4*j -: 4] = TabS[j][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32 - int'(TabP[i])];
    return p;
  endfunction

endpackage

// ===== rtl/des_keysched.sv =====
// ----------------------------------------------------------------------------
// DES key schedule
// Register the sixteen round keys from the configured key.
// ----------------------------------------------------------------------------
module des_keysched (
  input  logic clk,
  input  logic key_we,
  input  des_pkg::block_t key_in,
  output des_pkg::subkey_t subkeys [des_pkg::ROUND_COUNT]
);
  import des_pkg::*;

  logic [55:0] cd;
  khalf_t c [ROUND_COUNT+1];
  khalf_t d [ROUND_COUNT+1];

  // User keeps key changes to idle (unenforced); keys precomputed per write.
  always_ff @(posedge clk) begin
    if (key_we) begin
      cd <= perm_pc1(key_in);
    end
  end

  assign c[0] = cd[55:28];
  assign d[0] = cd[27:0];

  for (genvar n = 0; n < ROUND_COUNT; n++) begin : g_rk
    assign c[n+1] = rot28(c[n], TabRot[n]);
    assign d[n+1] = rot28(d[n], TabRot[n]);
    always_ff @(posedge clk) begin
      subkeys[n] <= perm_pc2({c[n+1], d[n+1]});
    end
  end
endmodule

// ===== rtl/des_round.sv =====
// ----------------------------------------------------------------------------
// DES round stage
// One Feistel round between registers; valid travels with the halves.
// ----------------------------------------------------------------------------
module des_round (
  input  logic clk,
  input  logic rst,
  input  des_pkg::rnd_t in_st,
  input  des_pkg::subkey_t subkey,
  output des_pkg::rnd_t out_st
);
  import des_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_st.valid <= 1'b0;
    end else begin
      out_st.valid <= in_st.valid;
    end
    out_st.l <= in_st.r;
    out_st.r <= in_st.l ^ feistel(in_st.r, subkey);
  end
endmodule

// ===== rtl/des_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// DES block encrypt
// Fully pipelined DES encryption, one round per stage.
// ----------------------------------------------------------------------------
// Path: start to done runs through IP register, 16 rounds, FP register.
// Throughput: one block per cycle; busy is never raised, the pipeline of
//   sixteen round stages sets the latency and the receiver cannot stall.
// Reset: rst (synchronous, active high) clears all valid bits and the key to
//   zero; after a key write the round keys follow via the cd and subkey registers.
// ----------------------------------------------------------------------------
module des_block_encrypt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  des_pkg::block_t plain_block,
  input  logic cipher_key_we,
  input  des_pkg::block_t cipher_key,
  output logic done,
  output des_pkg::block_t cipher_block
);
  import des_pkg::*;

  rnd_t st [ROUND_COUNT+1];
  subkey_t subkeys [ROUND_COUNT];
  block_t ip_out;
  logic key_load;
  block_t key_val;

  // Load zero on reset so the schedule matches the reset key.
  assign key_load = rst | cipher_key_we;
  assign key_val = rst ? '0 : cipher_key;

  des_keysched u_keys (
    .clk(clk), .key_we(key_load), .key_in(key_val), .subkeys(subkeys)
  );

  assign busy = 1'b0;
  assign ip_out = perm_ip(plain_block);

  // Stage 0: register the initial permutation.
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0].valid <= start;
    end
    st[0].l <= ip_out[63:32];
    st[0].r <= ip_out[31:0];
  end

  for (genvar n = 0; n < ROUND_COUNT; n++) begin : g_rnd
    des_round u_rnd (
      .clk(clk), .rst(rst), .in_st(st[n]), .subkey(subkeys[n]), .out_st(st[n+1])
    );
  end

  // Output: swap halves, apply final permutation, hold for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st[ROUND_COUNT].valid;
    end
    cipher_block <= perm_fp({st[ROUND_COUNT].r, st[ROUND_COUNT].l});
  end
endmodule

// ===== rtl/des_checker.sv =====
// ----------------------------------------------------------------------------
// DES port checker
// Port-level timing checks for the encrypt pipeline.
// ----------------------------------------------------------------------------
module des_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##18 done)
    else $error("missing result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 18))
    else $error("unrequested result");
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done after reset");
endmodule

bind des_block_encrypt des_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);

// ===== dv/des_block_encrypt_test.sv =====
// ----------------------------------------------------------------------------
// DES block encrypt testbench
// Sends plaintext blocks under a series of keys and checks each ciphertext
// against a behavioral DES cipher kept in this file. The set of keys covers
// zero, all ones, weak keys, keys that differ only in the parity bits, and
// random keys.
// ----------------------------------------------------------------------------
module des_block_encrypt_test;
  import des_pkg::*;

  localparam int PIPE_DELAY = 18;  // start to done through the pipeline
  localparam int KEY_SETTLE = 4;   // wait after a key write for the round keys to follow

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  block_t plain_block = '0;
  logic cipher_key_we = 1'b0;
  block_t cipher_key = '0;
  logic done;
  block_t cipher_block;

  block_t cur_key = '0;           // key held by the predictor
  block_t cipher_queue[$];        // ciphertexts still due from the block
  int mismatch_count = 0;
  bit burst_mode = 1'b0;          // when set, send requests back to back

  des_block_encrypt i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .plain_block(plain_block),
    .cipher_key_we(cipher_key_we),
    .cipher_key(cipher_key),
    .done(done),
    .cipher_block(cipher_block)
  );

  always #10 clk = ~clk;

  // Compute the DES ciphertext of one block: key schedule from PC-1,
  // rotations and PC-2, sixteen Feistel rounds between IP and FP.
  function automatic block_t des_cipher(block_t key, block_t pt);
    logic [55:0] cd;
    logic [55:0] cd_rot;
    khalf_t c;
    khalf_t d;
    block_t ip_out;
    block_t pre_fp;
    block_t ct;
    half_t l;
    half_t r;
    half_t t;
    half_t sbox_out;
    half_t f_out;
    subkey_t k;
    subkey_t x;
    logic [5:0] six;
    logic [1:0] row;
    logic [3:0] col;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(TabPc1[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 64; i++) ip_out[63-i] = pt[64 - int'(TabIp[i])];
    l = ip_out[63:32];
    r = ip_out[31:0];
    for (int n = 0; n < ROUND_COUNT; n++) begin
      // rotate each key half left by one or two places
      for (int s = 0; s < int'(TabRot[n]); s++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd_rot = {c, d};
      for (int i = 0; i < 48; i++) k[47-i] = cd_rot[56 - int'(TabPc2[i])];
      for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
      x = x ^ k;
      for (int j = 0; j < 8; j++) begin
        six = x[47-6*j -: 6];
        row = {six[5], six[0]};   // outer bits pick the row
        col = six[4:1];           // inner bits pick the column
        sbox_out[31-4*j -: 4] = TabS[j][row*16 + col];
      end
      for (int i = 0; i < 32; i++) f_out[31-i] = sbox_out[32 - int'(TabP[i])];
      t = l ^ f_out;
      l = r;
      r = t;
    end
    // halves swap before the final permutation
    pre_fp = {r, l};
    for (int i = 0; i < 64; i++) ct[63-i] = pre_fp[64 - int'(TabFp[i])];
    return ct;
  endfunction

  task automatic report_mismatch(string what, block_t got, block_t want);
    $display("[%0t] mismatch %s: got %016h want %016h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Check every ciphertext the block strobes out against the oldest one due.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (cipher_queue.size() == 0) begin
        report_mismatch("unexpected result", cipher_block, '0);
      end else begin
        if (cipher_block !== cipher_queue[0])
          report_mismatch("cipher_block", cipher_block, cipher_queue[0]);
        void'(cipher_queue.pop_front());
      end
    end
  end

  // Send one plaintext request; hold start until the block takes it.
  task automatic send_block(block_t pt);
    int gap;
    logic was_busy;
    gap = 0;
    if (!burst_mode && $urandom_range(99) < 35) gap = $urandom_range(2, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    plain_block <= pt;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    cipher_queue = {cipher_queue, des_cipher(cur_key, pt)};
  endtask

  // Drop start and wait until every ciphertext due has come back.
  task automatic drain;
    start <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DELAY + 2) @(posedge clk);
  endtask

  // Write the key while idle and hold off until the round keys follow.
  task automatic load_key(block_t key);
    cipher_key_we <= 1'b1;
    cipher_key <= key;
    @(posedge clk);
    cipher_key_we <= 1'b0;
    cur_key = key;
    repeat (KEY_SETTLE) @(posedge clk);
  endtask

  function automatic block_t rand_block();
    return {$urandom(), $urandom()};
  endfunction

  // Key left at its reset value of zero; extremes of the plaintext.
  task automatic test_reset_key;
    send_block('0);
    send_block('1);
    send_block(64'hAAAA_AAAA_AAAA_AAAA);
    send_block(64'h5555_5555_5555_5555);
    send_block(64'h8000_0000_0000_0001);
    drain();
  endtask

  // Textbook key and plaintext, plus all-ones key.
  task automatic test_known_vector;
    load_key(64'h1334_5779_9BBC_DFF1);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block('0);
    drain();
    load_key('1);
    send_block('0);
    send_block('1);
    send_block(64'h0123_4567_89AB_CDEF);
    drain();
  endtask

  // Weak keys are used as given, nothing is rejected.
  task automatic test_weak_keys;
    load_key(64'h0101_0101_0101_0101);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block('1);
    drain();
    load_key(64'hFEFE_FEFE_FEFE_FEFE);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block('0);
    drain();
  endtask

  // Flip only the parity bits; the ciphertext must not change.
  task automatic test_parity_bits;
    load_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101);
    send_block(64'h0123_4567_89AB_CDEF);
    drain();
    load_key(64'h0101_0101_0101_0101 ^ 64'h0101_0101_0101_0101);
    send_block(64'hFFFF_0000_FFFF_0000);
    drain();
  endtask

  // Random keys and plaintext, with random gaps except in the burst phase.
  task automatic test_random_blocks;
    for (int phase = 0; phase < 10; phase++) begin
      load_key(rand_block());
      burst_mode = (phase == 4);
      repeat (95) send_block(rand_block());
      drain();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_known_vector();
    test_weak_keys();
    test_parity_bits();
    test_random_blocks();
    if (mismatch_count == 0 && cipher_queue.size() == 0) begin
      $display("** des_block_encrypt: PASSED **");
    end else begin
      $display("** des_block_encrypt: FAILED **");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("** des_block_encrypt: FAILED **");
    $finish;
  end

endmodule
